### hw/rtl/gsw_pkg.sv
// gsw_pkg: shared types, register codes and helpers of the register write handler
`default_nettype none

package gsw_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_CHECK = 2'd2
  } kind_t;

  // register address codes
  localparam logic [7:0] REG_BITBLTBUF = 8'h50;
  localparam logic [7:0] REG_TRXREG    = 8'h52;
  localparam logic [7:0] REG_TRXDIR    = 8'h53;
  localparam logic [7:0] REG_SIGNAL    = 8'h60;
  localparam logic [7:0] REG_FINISH    = 8'h61;
  localparam logic [7:0] REG_LABEL     = 8'h62;

  // configuration register indexes
  localparam logic [7:0] CFG_SIGNAL_IRQ_MASKED = 8'd0;
  localparam logic [7:0] CFG_FINISH_IRQ_MASKED = 8'd1;

  // transfer direction code for local-to-host
  localparam logic [1:0] DIR_LOCAL_TO_HOST = 2'd1;

  // source pixel format codes
  localparam logic [2:0] FMT_32 = 3'd0;
  localparam logic [2:0] FMT_24 = 3'd1;
  localparam logic [2:0] FMT_16 = 3'd2;
  localparam logic [2:0] FMT_8  = 3'd3;

  localparam int unsigned SizeW = 22;
  localparam int unsigned AreaW = 24;

  typedef struct packed {
    logic signal_irq_masked;
    logic finish_irq_masked;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  reg_addr;
    logic [63:0] write_data;
    logic        clear_signal;
    logic        clear_finish;
  } item_t;

  typedef struct packed {
    logic [2:0]       source_format;
    logic [11:0]      rect_width;
    logic [11:0]      rect_height;
    logic             signal_flag;
    logic             finish_flag;
    logic             pending_flag;
    logic [63:0]      pending_data;
    logic [31:0]      sig_id;
    logic [31:0]      label_id;
    logic [SizeW-1:0] download_size;
  } state_t;

  typedef struct packed {
    logic             stall_res;
    logic             irq;
    logic             signal_set;
    logic             finish_set;
    logic             signal_queued;
    logic [63:0]      queued_signal_data;
    logic [31:0]      signal_id;
    logic [31:0]      label_id;
    logic [SizeW-1:0] download_quadwords;
    logic             format_error;
  } result_t;

  // low half is the value, high half selects the bits to change
  function automatic logic [31:0] masked_update(input logic [31:0] old_val,
                                                input logic [63:0] data);
    logic [31:0] val;
    logic [31:0] msk;
    val = data[31:0];
    msk = data[63:32];
    return (old_val & ~msk) | (val & msk);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gsw_exec.sv
// gsw_exec: combinational update of the handler state and result for one item
`default_nettype none

module gsw_exec (
  input  gsw_pkg::cfg_t    cfg,
  input  gsw_pkg::item_t   item,
  input  gsw_pkg::state_t  cur,
  output gsw_pkg::state_t  nxt,
  output gsw_pkg::result_t res
);
  import gsw_pkg::*;

  logic [AreaW-1:0]   area;
  logic [AreaW+4:0]   scaled;
  logic               fmt_bad;
  logic               stall;
  logic               irq_out;
  logic               fmt_err;

  // rectangle area in pixels
  assign area = {12'd0, cur.rect_width} * {12'd0, cur.rect_height};

  // area times bits per pixel, done as shifts and one add
  always_comb begin
    fmt_bad = 1'b0;
    case (cur.source_format)
      FMT_32:  scaled = {5'd0, area} << 5;
      FMT_24:  scaled = ({5'd0, area} << 4) + ({5'd0, area} << 3);
      FMT_16:  scaled = {5'd0, area} << 4;
      FMT_8:   scaled = {5'd0, area} << 3;
      default: begin
        scaled  = {5'd0, area} << 5;
        fmt_bad = 1'b1;
      end
    endcase
  end

  // state update per item kind
  always_comb begin
    nxt     = cur;
    stall   = 1'b0;
    irq_out = 1'b0;
    fmt_err = 1'b0;
    case (item.kind)
      KIND_WRITE: begin
        case (item.reg_addr)
          REG_BITBLTBUF: nxt.source_format = item.write_data[26:24];
          REG_TRXREG: begin
            nxt.rect_width  = item.write_data[11:0];
            nxt.rect_height = item.write_data[43:32];
          end
          REG_TRXDIR: begin
            if (item.write_data[1:0] == DIR_LOCAL_TO_HOST) begin
              nxt.download_size = scaled[AreaW+4:7];
              fmt_err           = fmt_bad;
            end
          end
          REG_SIGNAL: begin
            if (cur.signal_flag) begin
              // one stalled signal is held, later ones are dropped
              if (!cur.pending_flag) begin
                nxt.pending_flag = 1'b1;
                nxt.pending_data = item.write_data;
                stall            = 1'b1;
              end
            end else begin
              nxt.sig_id      = masked_update(cur.sig_id, item.write_data);
              irq_out         = !cfg.signal_irq_masked;
              nxt.signal_flag = 1'b1;
            end
          end
          REG_FINISH: nxt.finish_flag = 1'b1;
          REG_LABEL:  nxt.label_id = masked_update(cur.label_id, item.write_data);
          default:    nxt = cur;
        endcase
      end
      KIND_CLEAR: begin
        if (item.clear_signal) begin
          nxt.signal_flag  = 1'b0;
          nxt.pending_flag = 1'b0;
          nxt.pending_data = '0;
        end
        if (item.clear_finish) begin
          nxt.finish_flag = 1'b0;
        end
      end
      KIND_CHECK: irq_out = cur.finish_flag && !cfg.finish_irq_masked;
      default:    nxt = cur;
    endcase
  end

  // result reports the state after the item
  always_comb begin
    res.stall_res          = stall;
    res.irq                = irq_out;
    res.signal_set         = nxt.signal_flag;
    res.finish_set         = nxt.finish_flag;
    res.signal_queued      = nxt.pending_flag;
    res.queued_signal_data = nxt.pending_flag ? nxt.pending_data : 64'd0;
    res.signal_id          = nxt.sig_id;
    res.label_id           = nxt.label_id;
    res.download_quadwords = nxt.download_size;
    res.format_error       = fmt_err;
  end

endmodule

`default_nettype wire

### hw/rtl/gs_side_register_write_handler_unit.sv
// gs_side_register_write_handler_unit: top level of the register write side handler
// pipe: the input register holds an accepted item, the result register its result
// throughput: one item per cycle while out_ready is high; the two form a two-stage pipe
// the next item is taken while a finished result still waits on out_ready
// reset: all state and flags clear, both interrupt masks set, pipe empty
`default_nettype none

module gs_side_register_write_handler_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  reg_addr,
  input  wire logic [63:0] write_data,
  input  wire logic        clear_signal,
  input  wire logic        clear_finish,
  // result item channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             stall_res,
  output logic             irq,
  output logic             signal_set,
  output logic             finish_set,
  output logic             signal_queued,
  output logic [63:0]      queued_signal_data,
  output logic [31:0]      signal_id,
  output logic [31:0]      label_id,
  output logic [21:0]      download_quadwords,
  output logic             format_error
);
  import gsw_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  state_t  state;
  state_t  state_next;
  result_t result;
  result_t result_next;
  logic    advance;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.signal_irq_masked <= 1'b1;
      cfg.finish_irq_masked <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SIGNAL_IRQ_MASKED) begin
        cfg.signal_irq_masked <= cfg_data[0];
      end
      if (cfg_index == CFG_FINISH_IRQ_MASKED) begin
        cfg.finish_irq_masked <= cfg_data[0];
      end
    end
  end

  // pipe control
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.kind         <= kind;
      item.reg_addr     <= reg_addr;
      item.write_data   <= write_data;
      item.clear_signal <= clear_signal;
      item.clear_finish <= clear_finish;
    end
  end

  gsw_exec u_exec (
    .cfg  (cfg),
    .item (item),
    .cur  (state),
    .nxt  (state_next),
    .res  (result_next)
  );

  // handler state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign stall_res          = result.stall_res;
  assign irq                = result.irq;
  assign signal_set         = result.signal_set;
  assign finish_set         = result.finish_set;
  assign signal_queued      = result.signal_queued;
  assign queued_signal_data = result.queued_signal_data;
  assign signal_id          = result.signal_id;
  assign label_id           = result.label_id;
  assign download_quadwords = result.download_quadwords;
  assign format_error       = result.format_error;

endmodule

`default_nettype wire

### hw/rtl/gsw_checker.sv
// gsw_checker: port-level assertions for the register write handler, with its bind
`default_nettype none

module gsw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        stall_res,
  input wire logic        irq,
  input wire logic        signal_set,
  input wire logic        signal_queued,
  input wire logic [63:0] queued_signal_data,
  input wire logic [31:0] signal_id,
  input wire logic [21:0] download_quadwords
);

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a held result keeps its signal_id, irq and download_quadwords
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(signal_id) && $stable(irq)
      && $stable(download_quadwords))
    else $error("stalled result changed");

  // a queued signal only exists while the signal flag is set
  a_queue_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && signal_queued |-> signal_set)
    else $error("queued signal without signal flag");

  // a stall always leaves an entry queued
  a_stall_queue: assert property (@(posedge clk) disable iff (rst)
    out_valid && stall_res |-> signal_queued && !irq)
    else $error("stall without queued entry");

  // no queued entry shows zero data
  a_queue_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !signal_queued |-> queued_signal_data == 64'd0)
    else $error("queued data without queued entry");

endmodule

bind gs_side_register_write_handler_unit gsw_checker u_gsw_checker (.*);

`default_nettype wire

### bench/gs_side_register_write_handler_unit_tb.sv
// self-checking bench for the register write side handler: directed and random traffic
module gs_side_register_write_handler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsw_pkg::*;

  // codes that the package leaves unnamed
  localparam logic [1:0] KIND_UNUSED        = 2'd3;
  localparam logic [1:0] DIR_HOST_TO_LOCAL  = 2'd0;
  localparam logic [1:0] DIR_LOCAL_TO_LOCAL = 2'd2;
  localparam logic [1:0] DIR_DEACTIVATED    = 2'd3;
  localparam logic [2:0] FMT_ILLEGAL        = 3'd7;
  localparam logic [7:0] REG_UNUSED_LOW     = 8'h00;
  localparam logic [7:0] REG_UNUSED_HIGH    = 8'hFF;
  localparam logic [7:0] REG_UNUSED_GAP     = 8'h51;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_ITEMS   = 340;
  localparam int unsigned PRINT_LIMIT   = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [7:0]  reg_addr = '0;
  logic [63:0] write_data = '0;
  logic        clear_signal = 1'b0;
  logic        clear_finish = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        stall_res;
  logic        irq;
  logic        signal_set;
  logic        finish_set;
  logic        signal_queued;
  logic [63:0] queued_signal_data;
  logic [31:0] signal_id;
  logic [31:0] label_id;
  logic [21:0] download_quadwords;
  logic        format_error;

  // shadow of the handler state and interrupt masks
  logic        mask_signal_irq = 1'b1;
  logic        mask_finish_irq = 1'b1;
  logic [2:0]  st_format = '0;
  logic [11:0] st_width = '0;
  logic [11:0] st_height = '0;
  logic        st_signal = 1'b0;
  logic        st_finish = 1'b0;
  logic        st_queued = 1'b0;
  logic [63:0] st_queued_data = '0;
  logic [31:0] st_signal_id = '0;
  logic [31:0] st_label_id = '0;
  logic [21:0] st_quadwords = '0;

  result_t     expected_status [$];
  int unsigned items_sent = 0;
  int unsigned items_counted = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  gs_side_register_write_handler_unit u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .kind               (kind),
    .reg_addr           (reg_addr),
    .write_data         (write_data),
    .clear_signal       (clear_signal),
    .clear_finish       (clear_finish),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .stall_res          (stall_res),
    .irq                (irq),
    .signal_set         (signal_set),
    .finish_set         (finish_set),
    .signal_queued      (signal_queued),
    .queued_signal_data (queued_signal_data),
    .signal_id          (signal_id),
    .label_id           (label_id),
    .download_quadwords (download_quadwords),
    .format_error       (format_error)
  );

  always #4 clk = ~clk;

  // status after one item, advancing the shadow state
  function automatic result_t next_status(input logic [1:0] k, input logic [7:0] addr,
                                          input logic [63:0] data, input logic clr_sig,
                                          input logic clr_fin);
    result_t     r;
    int unsigned bpp;
    logic [31:0] bits;
    r = '0;
    bpp = 32;
    if (k == KIND_WRITE) begin
      case (addr)
        REG_BITBLTBUF: st_format = data[26:24];
        REG_TRXREG: begin
          st_width  = data[11:0];
          st_height = data[43:32];
        end
        REG_TRXDIR: begin
          if (data[1:0] == DIR_LOCAL_TO_HOST) begin
            case (st_format)
              FMT_32: bpp = 32;
              FMT_24: bpp = 24;
              FMT_16: bpp = 16;
              FMT_8:  bpp = 8;
              default: begin
                bpp = 32;
                r.format_error = 1'b1;
              end
            endcase
            // largest product is below 2^32, size is bits above the low seven
            bits = st_width * st_height * bpp;
            st_quadwords = bits[28:7];
          end
        end
        REG_SIGNAL: begin
          if (st_signal) begin
            if (!st_queued) begin
              st_queued      = 1'b1;
              st_queued_data = data;
              r.stall_res    = 1'b1;
            end
          end else begin
            st_signal_id = (st_signal_id & ~data[63:32]) | (data[31:0] & data[63:32]);
            r.irq        = !mask_signal_irq;
            st_signal    = 1'b1;
          end
        end
        REG_FINISH: st_finish = 1'b1;
        REG_LABEL:  st_label_id = (st_label_id & ~data[63:32]) | (data[31:0] & data[63:32]);
        default: ;
      endcase
    end else if (k == KIND_CLEAR) begin
      if (clr_sig) begin
        st_signal      = 1'b0;
        st_queued      = 1'b0;
        st_queued_data = '0;
      end
      if (clr_fin) st_finish = 1'b0;
    end else if (k == KIND_CHECK) begin
      r.irq = st_finish && !mask_finish_irq;
    end
    r.signal_set         = st_signal;
    r.finish_set         = st_finish;
    r.signal_queued      = st_queued;
    r.queued_signal_data = st_queued ? st_queued_data : '0;
    r.signal_id          = st_signal_id;
    r.label_id           = st_label_id;
    r.download_quadwords = st_quadwords;
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // rectangle side: mostly random, often an extreme
  function automatic logic [11:0] pick_side();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 12'($urandom_range(1, 16));
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [7:0] pick_known_reg();
    case ($urandom_range(5))
      0: return REG_BITBLTBUF;
      1: return REG_TRXREG;
      2: return REG_TRXDIR;
      3: return REG_SIGNAL;
      4: return REG_FINISH;
      default: return REG_LABEL;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < PRINT_LIMIT)
      $display("%0t ns  %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // capture accepted config writes and items into the shadow model
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIGNAL_IRQ_MASKED: mask_signal_irq = cfg_data[0];
        CFG_FINISH_IRQ_MASKED: mask_finish_irq = cfg_data[0];
        default: ;
      endcase
    end
    if (!rst && in_valid && in_ready)
      expected_status.push_back(next_status(kind, reg_addr, write_data, clear_signal,
                                            clear_finish));
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("result item with no item pending", 64'd1, 64'd0);
      end else begin
        want = expected_status.pop_front();
        if (stall_res !== want.stall_res)
          report_mismatch("stall_res", stall_res, want.stall_res);
        if (irq !== want.irq)
          report_mismatch("irq", irq, want.irq);
        if (signal_set !== want.signal_set)
          report_mismatch("signal_set", signal_set, want.signal_set);
        if (finish_set !== want.finish_set)
          report_mismatch("finish_set", finish_set, want.finish_set);
        if (signal_queued !== want.signal_queued)
          report_mismatch("signal_queued", signal_queued, want.signal_queued);
        if (queued_signal_data !== want.queued_signal_data)
          report_mismatch("queued_signal_data", queued_signal_data, want.queued_signal_data);
        if (signal_id !== want.signal_id)
          report_mismatch("signal_id", signal_id, want.signal_id);
        if (label_id !== want.label_id)
          report_mismatch("label_id", label_id, want.label_id);
        if (download_quadwords !== want.download_quadwords)
          report_mismatch("download_quadwords", download_quadwords, want.download_quadwords);
        if (format_error !== want.format_error)
          report_mismatch("format_error", format_error, want.format_error);
      end
      results_seen++;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // present one item, hold it until accepted; valid stays high for a back-to-back item
  task automatic send_item(input logic [1:0] k, input logic [7:0] addr,
                           input logic [63:0] data, input logic clr_sig,
                           input logic clr_fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    reg_addr     <= addr;
    write_data   <= data;
    clear_signal <= clr_sig;
    clear_finish <= clr_fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (k != KIND_UNUSED && !(k == KIND_WRITE && !(addr inside {REG_BITBLTBUF, REG_TRXREG,
        REG_TRXDIR, REG_SIGNAL, REG_FINISH, REG_LABEL})))
      items_counted++;
  endtask

  // fields of other kinds carry noise
  task automatic write_reg(input logic [7:0] addr, input logic [63:0] data);
    send_item(KIND_WRITE, addr, data, 1'($urandom), 1'($urandom));
  endtask

  task automatic clear_flags(input logic clr_sig, input logic clr_fin);
    send_item(KIND_CLEAR, 8'($urandom), rand_word(), clr_sig, clr_fin);
  endtask

  task automatic check_finish();
    send_item(KIND_CHECK, 8'($urandom), rand_word(), 1'($urandom), 1'($urandom));
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_seen < items_sent);
  endtask

  // write both interrupt masks, upper data bits are noise
  task automatic set_masks(input logic sig_m, input logic fin_m);
    logic [31:0] noise;
    noise = $urandom;
    noise[0] = sig_m;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SIGNAL_IRQ_MASKED;
    cfg_data  <= noise;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    noise = $urandom;
    noise[0] = fin_m;
    cfg_index <= CFG_FINISH_IRQ_MASKED;
    cfg_data  <= noise;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // transfer size for every format, extremes of the rectangle, other directions
  task automatic test_transfer_sizes();
    logic [63:0] d;
    logic [2:0]  fmts [4];
    fmts = '{FMT_32, FMT_16, FMT_8, FMT_ILLEGAL};
    d = rand_word();
    d[26:24] = FMT_24;
    write_reg(REG_BITBLTBUF, d);
    write_reg(REG_TRXREG, '1);
    d = rand_word();
    d[1:0] = DIR_LOCAL_TO_HOST;
    write_reg(REG_TRXDIR, d);
    foreach (fmts[i]) begin
      d = rand_word();
      d[26:24] = fmts[i];
      write_reg(REG_BITBLTBUF, d);
      d = rand_word();
      d[1:0] = DIR_LOCAL_TO_HOST;
      write_reg(REG_TRXDIR, d);
    end
    // zero rectangle; other directions keep the last size
    write_reg(REG_TRXREG, 64'h0);
    d = rand_word();
    d[1:0] = DIR_DEACTIVATED;
    write_reg(REG_TRXDIR, d);
    d[1:0] = DIR_HOST_TO_LOCAL;
    write_reg(REG_TRXDIR, d);
    d[1:0] = DIR_LOCAL_TO_LOCAL;
    write_reg(REG_TRXDIR, d);
    d[1:0] = DIR_LOCAL_TO_HOST;
    write_reg(REG_TRXDIR, d);
  endtask

  // signal under both mask settings, the stall, the ignored third write and the clear
  task automatic test_signal_stall();
    write_reg(REG_SIGNAL, '1);
    write_reg(REG_SIGNAL, rand_word());
    write_reg(REG_SIGNAL, rand_word());
    clear_flags(1'b1, 1'b0);
    wait_idle();
    set_masks(1'b0, 1'b0);
    write_reg(REG_SIGNAL, 64'hFFFF_0000_0000_0000);
    clear_flags(1'b1, 1'b1);
  endtask

  // finish flag, finish check with the mask open, label updates under a mask
  task automatic test_finish_and_label();
    check_finish();
    write_reg(REG_FINISH, rand_word());
    check_finish();
    clear_flags(1'b0, 1'b1);
    check_finish();
    write_reg(REG_LABEL, '1);
    write_reg(REG_LABEL, 64'h00FF_00FF_0000_0000);
  endtask

  // unknown registers, the unused kind, a clear with no bits set
  task automatic test_ignored_items();
    write_reg(REG_UNUSED_LOW, '1);
    write_reg(REG_UNUSED_HIGH, rand_word());
    write_reg(REG_UNUSED_GAP, rand_word());
    send_item(KIND_UNUSED, REG_SIGNAL, '1, 1'b1, 1'b1);
    clear_flags(1'b0, 1'b0);
  endtask

  // mostly well-formed register sequences with random content, some noise
  task automatic run_random_phase(input int unsigned n_items, input int unsigned idle_pct,
                                  input int unsigned stall_pct, input logic sig_m,
                                  input logic fin_m);
    int unsigned target;
    logic [63:0] d;
    wait_idle();
    set_masks(sig_m, fin_m);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_counted + n_items;
    while (items_counted < target) begin
      case ($urandom_range(9))
        0, 1: begin
          d = rand_word();
          d[26:24] = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
          write_reg(REG_BITBLTBUF, d);
          d = rand_word();
          d[11:0]  = pick_side();
          d[43:32] = pick_side();
          write_reg(REG_TRXREG, d);
          d = rand_word();
          if ($urandom_range(4) != 0) d[1:0] = DIR_LOCAL_TO_HOST;
          write_reg(REG_TRXDIR, d);
        end
        2, 3: begin
          repeat ($urandom_range(1, 3)) write_reg(REG_SIGNAL, rand_word());
          if ($urandom_range(1) != 0) check_finish();
          clear_flags($urandom_range(3) != 0, 1'($urandom));
        end
        4: begin
          write_reg(REG_FINISH, rand_word());
          check_finish();
          clear_flags(1'($urandom), $urandom_range(3) != 0);
        end
        5: write_reg(REG_LABEL, rand_word());
        6, 7: write_reg(pick_known_reg(), rand_word());
        8: send_item(2'($urandom_range(3)), 8'($urandom), rand_word(), 1'($urandom),
                     1'($urandom));
        default: clear_flags(1'($urandom), 1'($urandom));
      endcase
    end
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_transfer_sizes();
    test_signal_stall();
    test_finish_and_label();
    test_ignored_items();
    run_random_phase(PHASE_ITEMS, 0, 0, 1'b1, 1'b1);
    run_random_phase(PHASE_ITEMS, 79, 0, 1'b0, 1'b0);
    run_random_phase(PHASE_ITEMS, 0, 79, 1'b0, 1'b1);
    run_random_phase(PHASE_ITEMS, 17, 17, 1'b1, 1'b0);
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
